// ===== rtl/osw_pkg.sv =====
// ----------------------------------------------------------------------------
// osw_pkg
// shared types and constants of the one-sided window average block
// ----------------------------------------------------------------------------
package osw_pkg;

  // width of the signed window extent register
  localparam int HW_WIDTH = 7;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;    // take the input word, write it to history
    logic acc_step;  // issue one history read / add one entry to the sum
    logic div_go;    // start the divider on sum / count
    logic emit;      // load the quotient into the output register
    logic sub_rd;    // read the oldest entry of the current window
    logic sub;       // drop that entry from the sum, shrink the count
  } osw_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic has_result;  // the word being accepted produces at least one result
    logic acc_done;    // every window entry has been added
    logic div_busy;    // divider still iterating
    logic out_free;    // output register can take a word this cycle
    logic more;        // flush still has shorter windows to emit
  } osw_sts_t;

endpackage

// ===== rtl/osw_div.sv =====
// ----------------------------------------------------------------------------
// osw_div
// signed by unsigned restoring divider, one quotient bit per cycle,
// truncating toward zero
// ----------------------------------------------------------------------------
module osw_div #(
  parameter int DW = 38,
  parameter int VW = 7,
  parameter int QW = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [DW-1:0] dividend,
  input  logic        [VW-1:0] divisor,
  output logic                 busy,
  output logic        [QW-1:0] quotient
);

  localparam int SCW = $clog2(DW + 1);

  logic [DW-1:0]  quo;
  logic [VW-1:0]  rem;
  logic [VW-1:0]  dvs;
  logic           neg;
  logic [SCW-1:0] steps;

  logic [VW:0]    trial;
  logic           fits;
  logic [DW-1:0]  quo_signed;

  assign trial      = {rem, quo[DW-1]};
  assign fits       = trial >= {1'b0, dvs};
  assign quo_signed = neg ? (~quo + 1'b1) : quo;
  assign quotient   = quo_signed[QW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= SCW'(DW);
    end else if (busy) begin
      steps <= steps - 1'b1;
      if (steps == SCW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[DW-1];
      quo <= dividend[DW-1] ? (~dividend + 1'b1) : dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DW-2:0], fits};
      rem <= fits ? VW'(trial - {1'b0, dvs}) : trial[VW-1:0];
    end
  end

endmodule

// ===== rtl/osw_dp.sv =====
// ----------------------------------------------------------------------------
// osw_dp
// datapath: extent register, history ring, window sum, divider and
// output register
// ----------------------------------------------------------------------------
module osw_dp import osw_pkg::*; #(
  parameter int MAX_HALF_WINDOW = 63,
  parameter int SAMPLE_WIDTH    = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr,
  input  logic [HW_WIDTH-1:0]     cfg_value,
  input  logic [SAMPLE_WIDTH-1:0] sample,
  input  logic                    seq_end,
  input  osw_cmd_t                cmd,
  output osw_sts_t                sts,
  input  logic                    out_take,
  output logic                    out_valid,
  output logic [SAMPLE_WIDTH-1:0] average,
  output logic                    run_last,
  output logic                    seq_done
);

  localparam int AW    = $clog2(MAX_HALF_WINDOW + 1) < 1 ? 1 : $clog2(MAX_HALF_WINDOW + 1);
  localparam int DEPTH = 1 << AW;
  localparam int CW    = AW + 1;
  localparam int SW    = SAMPLE_WIDTH + AW;
  localparam logic [7:0] MAXK = 8'(MAX_HALF_WINDOW);

  logic [HW_WIDTH-1:0]     half_window;
  logic [SAMPLE_WIDTH-1:0] history [DEPTH];
  logic [SAMPLE_WIDTH-1:0] rd_data;
  logic [AW-1:0]           write_slot;
  logic [CW-1:0]           samples_seen;
  logic signed [SW-1:0]    window_sum;
  logic [CW-1:0]           count;
  logic [CW-1:0]           back;
  logic                    pend;
  logic                    flush;
  logic                    last;

  logic [CW-1:0]           seen_next;
  logic [HW_WIDTH-1:0]     k_abs;
  logic [7:0]              k_clip;
  logic [7:0]              k_plus1;
  logic [7:0]              cnt_wide;
  logic [CW-1:0]           cnt_next;
  logic                    look_ahead;
  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic signed [SW-1:0]    rd_ext;
  logic                    div_busy;
  logic [SAMPLE_WIDTH-1:0] quotient;

  // window count for the word being accepted
  always_comb begin
    seen_next  = (samples_seen == CW'(DEPTH)) ? samples_seen : samples_seen + 1'b1;
    k_abs      = half_window[HW_WIDTH-1] ? (~half_window + 1'b1) : half_window;
    k_clip     = ({1'b0, k_abs} > MAXK) ? MAXK : {1'b0, k_abs};
    k_plus1    = k_clip + 8'd1;
    look_ahead = !half_window[HW_WIDTH-1] && (half_window != '0);
    if (half_window == '0) begin
      cnt_wide = 8'd1;
    end else if (8'(seen_next) < k_plus1) begin
      cnt_wide = 8'(seen_next);
    end else begin
      cnt_wide = k_plus1;
    end
    cnt_next = cnt_wide[CW-1:0];
  end

  // history reads: newest-first during the sum, oldest of window on a drop
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = write_slot - AW'(1) - back[AW-1:0];
    if (cmd.acc_step && (back != count)) begin
      rd_en = 1'b1;
    end else if (cmd.sub_rd) begin
      rd_en   = 1'b1;
      rd_addr = write_slot - count[AW-1:0];
    end
  end

  assign rd_ext = SW'($signed(rd_data));

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      history[write_slot] <= sample;
    end
    if (rd_en) begin
      rd_data <= history[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_window <= '0;
    end else if (cfg_wr) begin
      half_window <= cfg_value;
    end
  end

  // sequence position and window bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot   <= '0;
      samples_seen <= '0;
      pend         <= 1'b0;
      window_sum   <= '0;
    end else begin
      pend <= cmd.acc_step && (back != count);
      if (cmd.accept) begin
        write_slot   <= write_slot + 1'b1;
        samples_seen <= seen_next;
        window_sum   <= '0;
      end else if (cmd.acc_step && pend) begin
        window_sum <= window_sum + rd_ext;
      end else if (cmd.sub) begin
        window_sum <= window_sum - rd_ext;
      end else if (cmd.emit && !sts.more && last) begin
        // sequence closed: next word starts a fresh ring
        write_slot   <= '0;
        samples_seen <= '0;
        window_sum   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      count <= cnt_next;
      back  <= '0;
      flush <= look_ahead && seq_end;
      last  <= seq_end;
    end else begin
      if (cmd.acc_step && (back != count)) begin
        back <= back + 1'b1;
      end
      if (cmd.sub) begin
        count <= count - 1'b1;
      end
    end
  end

  osw_div #(
    .DW (SW),
    .VW (CW),
    .QW (SAMPLE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_go),
    .dividend (window_sum),
    .divisor  (count),
    .busy     (div_busy),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      average  <= quotient;
      run_last <= !sts.more;
      seq_done <= !sts.more && last;
    end
  end

  always_comb begin
    sts.has_result = !(look_ahead && !seq_end && (8'(seen_next) < k_plus1));
    sts.acc_done   = (back == count) && !pend;
    sts.div_busy   = div_busy;
    sts.out_free   = !out_valid || out_take;
    sts.more       = flush && (count != CW'(1));
  end

endmodule

// ===== rtl/osw_ctrl.sv =====
// ----------------------------------------------------------------------------
// osw_ctrl
// sequencer: accept, sum the window, divide, emit, and walk the flush
// ----------------------------------------------------------------------------
module osw_ctrl import osw_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  osw_sts_t sts,
  output osw_cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_ACC    = 6'b000010,
    ST_DIV_GO = 6'b000100,
    ST_DIV    = 6'b001000,
    ST_SUB_RD = 6'b010000,
    ST_SUB    = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.has_result) begin
            state_next = ST_ACC;
          end
        end
      end
      ST_ACC: begin
        cmd.acc_step = 1'b1;
        if (sts.acc_done) begin
          state_next = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        cmd.div_go = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (!sts.div_busy && sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = sts.more ? ST_SUB_RD : ST_IDLE;
        end
      end
      ST_SUB_RD: begin
        cmd.sub_rd = 1'b1;
        state_next = ST_SUB;
      end
      ST_SUB: begin
        cmd.sub    = 1'b1;
        state_next = ST_DIV_GO;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/one_sided_window_average.sv =====
// ----------------------------------------------------------------------------
// one_sided_window_average
// one-sided moving average of a signed fixed-point stream, clipped at the
// sequence edges, with a look-back, look-ahead or pass-through mode
// ----------------------------------------------------------------------------
//
// channel   dir  handshake            word contents
// --------  ---  -------------------  ----------------------------------------
// in        in   in_tvalid/in_tready  tdata: sample, tlast: seq_end
// out       out  out_tvalid/out_tready tdata: average, tlast: run_last,
//                                     tuser: seq_done
// cfg       in   cfg_valid/cfg_ready  cfg_data: half_window (always ready)
//
// one word is worked on at a time. a word is accepted, then its n-entry
// window is summed from the history ring (one read port, one entry a
// cycle, then the last entry is added and the sum seen done), the divider
// is launched, the bit-serial divider runs and the result is emitted once
// the output is free. each further flush result reads the oldest entry of
// the window, drops it from the sum, runs the divider again and is emitted.
// a word that completes no window (look-ahead, window not yet full) is
// only accepted. rst is synchronous and clears control state and the extent.
// a stalled output holds the result register; the next input word is taken
// as soon as the sequencer is back in idle, even while that result waits.
//
module one_sided_window_average import osw_pkg::*; #(
  parameter int MAX_HALF_WINDOW = 63,
  parameter int SAMPLE_WIDTH    = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [HW_WIDTH-1:0]   cfg_data,
  // input words
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,  // [SAMPLE_WIDTH-1:0] sample
  input  logic                  in_tlast,    // seq_end
  // result words
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] out_tdata, // [SAMPLE_WIDTH-1:0] average
  output logic                  out_tlast,   // run_last
  output logic                  out_tuser    // seq_done
);

  // tdata is padded up to whole bytes
  localparam int DBW = ((SAMPLE_WIDTH + 7) / 8) * 8;

  osw_cmd_t                cmd;
  osw_sts_t                sts;
  logic [SAMPLE_WIDTH-1:0] average;

  // writes must arrive only while idle (not enforced here); the register is always open
  assign cfg_ready = 1'b1;

  osw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  osw_dp #(
    .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
    .SAMPLE_WIDTH    (SAMPLE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_valid),
    .cfg_value (cfg_data),
    .sample    (in_tdata[SAMPLE_WIDTH-1:0]),
    .seq_end   (in_tlast),
    .cmd       (cmd),
    .sts       (sts),
    .out_take  (out_tready),
    .out_valid (out_tvalid),
    .average   (average),
    .run_last  (out_tlast),
    .seq_done  (out_tuser)
  );

  // zero fill above the average field
  assign out_tdata = DBW'(average);

endmodule
